### src/v2n_pkg.sv
// Shared types and constants for the vector2_normalize pipeline.
// No dependencies.
package v2n_pkg;

    localparam int unsigned SQRT_STEPS = 32;
    localparam int unsigned DIV_STEPS  = 31;

    typedef struct packed {
        logic [63:0] rad;
        logic [34:0] rem;
        logic [31:0] root;
        logic [31:0] mag_x;
        logic [31:0] mag_y;
        logic        neg_x;
        logic        neg_y;
    } t_sqrt_data;

    typedef struct packed {
        logic [31:0] rem_x;
        logic [31:0] rem_y;
        logic [30:0] q_x;
        logic [30:0] q_y;
        logic        low_x;
        logic        low_y;
        logic [31:0] len;
        logic        neg_x;
        logic        neg_y;
    } t_div_data;

endpackage

### src/v2n_sqrt_cell.sv
// One digit-by-digit square root cell: settles one bit of the root.
// Depends on v2n_pkg.
module v2n_sqrt_cell (
    input  logic                i_clk,
    input  logic                i_en,
    input  v2n_pkg::t_sqrt_data i_d,
    output v2n_pkg::t_sqrt_data o_q
);
    import v2n_pkg::*;

    t_sqrt_data  r_q;
    t_sqrt_data  n_q;
    logic [34:0] w_cur;
    logic [34:0] w_trial;

    always_comb begin
        w_cur   = {i_d.rem[32:0], i_d.rad[63:62]};
        w_trial = {1'b0, i_d.root, 2'b01};
        n_q     = i_d;
        n_q.rad = {i_d.rad[61:0], 2'b00};
        if (w_cur >= w_trial) begin
            n_q.rem  = w_cur - w_trial;
            n_q.root = {i_d.root[30:0], 1'b1};
        end else begin
            n_q.rem  = w_cur;
            n_q.root = {i_d.root[30:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

### src/v2n_div_cell.sv
// One restoring divide cell: settles one quotient bit for both components.
// Depends on v2n_pkg.
module v2n_div_cell (
    input  logic               i_clk,
    input  logic               i_en,
    input  v2n_pkg::t_div_data i_d,
    output v2n_pkg::t_div_data o_q
);
    import v2n_pkg::*;

    t_div_data   r_q;
    t_div_data   n_q;
    logic [32:0] w_cur_x;
    logic [32:0] w_cur_y;
    logic [32:0] w_len;

    always_comb begin
        w_cur_x   = {i_d.rem_x, i_d.low_x};
        w_cur_y   = {i_d.rem_y, i_d.low_y};
        w_len     = {1'b0, i_d.len};
        n_q       = i_d;
        n_q.low_x = 1'b0;
        n_q.low_y = 1'b0;
        if (w_cur_x >= w_len) begin
            n_q.rem_x = 32'(w_cur_x - w_len);
            n_q.q_x   = {i_d.q_x[29:0], 1'b1};
        end else begin
            n_q.rem_x = w_cur_x[31:0];
            n_q.q_x   = {i_d.q_x[29:0], 1'b0};
        end
        if (w_cur_y >= w_len) begin
            n_q.rem_y = 32'(w_cur_y - w_len);
            n_q.q_y   = {i_d.q_y[29:0], 1'b1};
        end else begin
            n_q.rem_y = w_cur_y[31:0];
            n_q.q_y   = {i_d.q_y[29:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

### src/vector2_normalize.sv
// vector2_normalize: 2D vector normalization, top level.
// Depends on v2n_pkg, v2n_sqrt_cell and v2n_div_cell.
//
// Each transaction carries one vector (vec_x, vec_y) as signed 32-bit fixed
// point and yields one result: the truncated length floor(sqrt(x^2 + y^2))
// unsigned, at the scale of the inputs, and the unit vector as signed Q1.30
// (1.0 = 2^30), each component truncated toward zero. A zero vector gives
// length 0, a zero unit vector and zero_length high. The block is a fully
// pipelined chain: magnitude register, squaring, sum, then 32 square root
// cells (one root bit each) and 31 divide cells (one quotient bit each, both
// components side by side), then an output register, 67 register stages in
// all. It accepts one vector per cycle while o_ready is high; the result is
// taken at an edge where o_valid and i_ready are both high. The whole chain
// advances together: it holds while the output register is full and not
// taken, so o_ready is high while that register is empty or i_ready is high.
// There is no state between vectors and no configuration.
module vector2_normalize (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_vec_x,
    input  logic [31:0] i_vec_y,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_unit_x,
    output logic [31:0] o_unit_y,
    output logic [31:0] o_vec_length,
    output logic        o_zero_length
);
    import v2n_pkg::*;

    // magnitude, square, sum, sqrt cells, div cells, output
    localparam int unsigned NSTG = 3 + SQRT_STEPS + DIV_STEPS + 1;

    logic [NSTG-1:0] r_vld;
    logic            w_adv;

    // stage 0: magnitudes and signs
    logic [31:0] r_mag_x, r_mag_y;
    logic        r_neg_x, r_neg_y;
    // stage 1: squares
    logic [63:0] r_sq_x, r_sq_y;
    logic [31:0] r_m1_x, r_m1_y;
    logic        r_n1_x, r_n1_y;
    // stage 2: sum, first sqrt input
    t_sqrt_data  r_sq_in;

    t_sqrt_data  w_sqrt [SQRT_STEPS+1];
    t_div_data   w_div  [DIV_STEPS+1];

    // output register
    logic [31:0] r_unit_x, r_unit_y, r_len;
    logic        r_zero;

    logic [31:0] w_qx, w_qy;

    // Advance everything whenever the output slot is free or being taken.
    assign w_adv   = !r_vld[NSTG-1] || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_neg_x <= i_vec_x[31];
            r_neg_y <= i_vec_y[31];
            // two's complement negate; the most negative value maps to 2^31
            r_mag_x <= i_vec_x[31] ? (~i_vec_x + 32'd1) : i_vec_x;
            r_mag_y <= i_vec_y[31] ? (~i_vec_y + 32'd1) : i_vec_y;

            r_sq_x <= 64'(r_mag_x) * 64'(r_mag_x);
            r_sq_y <= 64'(r_mag_y) * 64'(r_mag_y);
            r_m1_x <= r_mag_x;
            r_m1_y <= r_mag_y;
            r_n1_x <= r_neg_x;
            r_n1_y <= r_neg_y;

            // sum is at most 2^63, exact in 64 bits
            r_sq_in.rad   <= r_sq_x + r_sq_y;
            r_sq_in.rem   <= '0;
            r_sq_in.root  <= '0;
            r_sq_in.mag_x <= r_m1_x;
            r_sq_in.mag_y <= r_m1_y;
            r_sq_in.neg_x <= r_n1_x;
            r_sq_in.neg_y <= r_n1_y;
        end
    end

    assign w_sqrt[0] = r_sq_in;

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        v2n_sqrt_cell u_cell (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_d   (w_sqrt[k]),
            .o_q   (w_sqrt[k+1])
        );
    end

    // Seed the divider: |c| <= length, so the quotient fits in 31 bits and
    // the top part of |c| * 2^30 starts as the partial remainder.
    always_comb begin
        w_div[0].rem_x = {1'b0, w_sqrt[SQRT_STEPS].mag_x[31:1]};
        w_div[0].rem_y = {1'b0, w_sqrt[SQRT_STEPS].mag_y[31:1]};
        w_div[0].low_x = w_sqrt[SQRT_STEPS].mag_x[0];
        w_div[0].low_y = w_sqrt[SQRT_STEPS].mag_y[0];
        w_div[0].q_x   = '0;
        w_div[0].q_y   = '0;
        w_div[0].len   = w_sqrt[SQRT_STEPS].root;
        w_div[0].neg_x = w_sqrt[SQRT_STEPS].neg_x;
        w_div[0].neg_y = w_sqrt[SQRT_STEPS].neg_y;
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        v2n_div_cell u_cell (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_d   (w_div[k]),
            .o_q   (w_div[k+1])
        );
    end

    assign w_qx = {1'b0, w_div[DIV_STEPS].q_x};
    assign w_qy = {1'b0, w_div[DIV_STEPS].q_y};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_len  <= w_div[DIV_STEPS].len;
            r_zero <= (w_div[DIV_STEPS].len == '0);
            // drop the quotient for a zero length, else apply the sign
            if (w_div[DIV_STEPS].len == '0) begin
                r_unit_x <= '0;
                r_unit_y <= '0;
            end else begin
                r_unit_x <= w_div[DIV_STEPS].neg_x ? (~w_qx + 32'd1) : w_qx;
                r_unit_y <= w_div[DIV_STEPS].neg_y ? (~w_qy + 32'd1) : w_qy;
            end
        end
    end

    assign o_unit_x      = r_unit_x;
    assign o_unit_y      = r_unit_y;
    assign o_vec_length  = r_len;
    assign o_zero_length = r_zero;

endmodule

### sim/vector2_normalize_test.sv
// Self-checking testbench for vector2_normalize: directed and random vectors.
// Depends on the vector2_normalize RTL only; predicts length and unit vector.
module vector2_normalize_test;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_vec_x;
    logic [31:0] i_vec_y;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_unit_x;
    logic [31:0] o_unit_y;
    logic [31:0] o_vec_length;
    logic        o_zero_length;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
    } t_vec;

    typedef struct packed {
        logic [31:0] ux;
        logic [31:0] uy;
        logic [31:0] len;
        logic        zero;
    } t_norm;

    localparam int N_RANDOM     = 1500;
    localparam int LATENCY      = 67;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_START   = 20;

    t_vec  vec_queue[$];
    t_norm norm_queue[$];
    int    errors;
    int    cycle_count;
    bit    loading_done;
    bit    quiet_phase;
    int    send_gap;
    int    recv_gap;
    int    hold_count;
    bit    hold_done;

    vector2_normalize uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_vec_x       (i_vec_x),
        .i_vec_y       (i_vec_y),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_unit_x      (o_unit_x),
        .o_unit_y      (o_unit_y),
        .o_vec_length  (o_vec_length),
        .o_zero_length (o_zero_length)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Bitwise integer square root of a 64-bit radicand, truncated.
    function automatic logic [63:0] floor_sqrt(input logic [63:0] num);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > num) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (num >= res + bitv) begin
                num = num - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic t_norm normalize(input t_vec v);
        t_norm       r;
        logic [63:0] mx, my, len, qx, qy;
        mx  = v.x[31] ? {32'd0, -v.x} : {32'd0, v.x};
        my  = v.y[31] ? {32'd0, -v.y} : {32'd0, v.y};
        len = floor_sqrt(mx * mx + my * my);
        if (len == 0) begin
            r = '{ux: 32'd0, uy: 32'd0, len: 32'd0, zero: 1'b1};
        end else begin
            qx = (mx << 30) / len;
            qy = (my << 30) / len;
            r.ux   = v.x[31] ? -qx[31:0] : qx[31:0];
            r.uy   = v.y[31] ? -qy[31:0] : qy[31:0];
            r.len  = len[31:0];
            r.zero = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [31:0] rand_component();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 255) - 128;
            1: return {{16{1'b0}}, 16'($urandom)};
            2: return 32'h8000_0000 + $urandom_range(0, 3);
            3: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    // Fill the pending queue: directed corners first, then random vectors.
    initial begin
        logic [31:0] corners[8];
        corners = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000};
        loading_done = 1'b0;
        for (int i = 0; i < 8; i++)
            for (int j = 0; j < 3; j++)
                vec_queue.push_back('{x: corners[i], y: corners[(i + j * 3) % 8]});
        vec_queue.push_back('{x: 32'h0, y: 32'h0});
        for (int i = 0; i < N_RANDOM; i++)
            vec_queue.push_back('{x: rand_component(), y: rand_component()});
        loading_done = 1'b1;
    end

    initial begin
        errors      = 0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_ready     = 1'b0;
        i_vec_x     = 32'd0;
        i_vec_y     = 32'd0;
        send_gap    = 0;
        recv_gap    = 0;
        hold_count  = 0;
        hold_done   = 1'b0;
        quiet_phase = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Driver: advance to the next vector once the current transaction is taken.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid  <= 1'b0;
                end else if (vec_queue.size() > 0) begin
                    i_valid <= 1'b1;
                    i_vec_x <= vec_queue[0].x;
                    i_vec_y <= vec_queue[0].y;
                    norm_queue.push_back(normalize(vec_queue[0]));
                    void'(vec_queue.pop_front());
                    quiet_phase <= (vec_queue.size() < 300);
                    if (!quiet_phase && $urandom_range(0, 9) == 0)
                        send_gap <= $urandom_range(1, 16);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each taken result, hold off once over HOLD_START are pending.
    always @(posedge i_clk) begin
        t_norm exp_r;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (norm_queue.size() == 0) begin
                    $display("%0t: unexpected result ux=%h uy=%h len=%h zero=%b", $time,
                             o_unit_x, o_unit_y, o_vec_length, o_zero_length);
                    errors = errors + 1;
                end else begin
                    exp_r = norm_queue.pop_front();
                    if (o_unit_x !== exp_r.ux) begin
                        $display("%0t: unit_x expected %h actual %h", $time, exp_r.ux, o_unit_x);
                        errors = errors + 1;
                    end
                    if (o_unit_y !== exp_r.uy) begin
                        $display("%0t: unit_y expected %h actual %h", $time, exp_r.uy, o_unit_y);
                        errors = errors + 1;
                    end
                    if (o_vec_length !== exp_r.len) begin
                        $display("%0t: vec_length expected %h actual %h", $time,
                                 exp_r.len, o_vec_length);
                        errors = errors + 1;
                    end
                    if (o_zero_length !== exp_r.zero) begin
                        $display("%0t: zero_length expected %b actual %b", $time,
                                 exp_r.zero, o_zero_length);
                        errors = errors + 1;
                    end
                end
            end
            if (!hold_done && norm_queue.size() > HOLD_START) begin
                i_ready    <= 1'b0;
                hold_count <= hold_count + 1;
                if (hold_count >= HOLD_CYCLES) hold_done <= 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_ready  <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (!quiet_phase && $urandom_range(0, 9) == 0)
                    recv_gap <= $urandom_range(1, 16);
            end
        end
    end

    // End of run: drain, let the pipe settle, then report.
    initial begin
        cycle_count = 0;
        @(posedge i_clk);
        while (!loading_done || vec_queue.size() > 0 || norm_queue.size() > 0
               || i_valid) begin
            @(posedge i_clk);
            cycle_count = cycle_count + 1;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("FAIL vector2_normalize");
                $finish;
            end
        end
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0 && norm_queue.size() == 0) begin
            $display("PASS vector2_normalize");
        end else begin
            $display("FAIL vector2_normalize");
        end
        $finish;
    end

endmodule
